// ----- hdl/ilc_pkg.sv -----
// ----------------------------------------------------------------------------
// ilc_pkg
// shared types, character codes, text kind and verdict codes of the ini line classifier
// ----------------------------------------------------------------------------
package ilc_pkg;

    // longest text accepted is MAX_TEXT-1 characters
    localparam int MAX_TEXT = 64;
    localparam int TLEN_W   = $clog2(MAX_TEXT);

    // text kind codes
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_SECTION = 2'd1;
    localparam logic [1:0] KIND_KEY     = 2'd2;
    localparam logic [1:0] KIND_VALUE   = 2'd3;

    // verdict codes
    localparam logic [1:0] VERDICT_BLANK   = 2'd0;
    localparam logic [1:0] VERDICT_SECTION = 2'd1;
    localparam logic [1:0] VERDICT_PAIR    = 2'd2;
    localparam logic [1:0] VERDICT_INVALID = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LBR   = 8'h5b;
    localparam logic [7:0] CH_RBR   = 8'h5d;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0] text_kind;
        logic [7:0] text_byte;
        logic       line_done;
        logic [1:0] verdict;
    } out_item_t;

    // character class flags of one byte
    typedef struct packed {
        logic zero;
        logic space;
        logic comment;
        logic name_start;
        logic name_char;
        logic value_char;
        logic lbr;
        logic rbr;
        logic eq;
        logic quote;
        logic blank;
    } char_class_t;

endpackage

// ----- hdl/ini_line_classifier_core.sv -----
// ----------------------------------------------------------------------------
// ini_line_classifier_core
// classifies ini lines arriving one byte per transaction
// ----------------------------------------------------------------------------
// the input channel (in_valid / in_ready / in_item) carries one line byte and
// a flag on the line's last byte. the output channel (out_valid / out_ready /
// out_item) returns exactly one result per input transaction, in order: the
// captured character with its kind, and on the last byte the line verdict.
// a transaction goes through an input register and then a result register,
// which loads it once it is free. throughput is one byte per cycle while the
// receiver keeps up, as the parse state machine takes one step per byte.
// while the receiver stalls, the result register holds and one more byte may
// wait in the input register; in_ready drops only when both are full.
// reset (rst_n, asynchronous, active low) empties both registers and puts the
// parser at line start, skipping leading whitespace.
// ----------------------------------------------------------------------------
module ini_line_classifier_core
    import ilc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic        out_free;
    logic        advance;
    char_class_t cls;
    out_item_t   step_result;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    ilc_char_class u_class (
        .line_byte (s1_item_reg.line_byte),
        .cls       (cls)
    );

    ilc_line_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_item_reg),
        .cls    (cls),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_item;
        if (advance)
            out_item_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // with the result register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // verdict is only given on a line's last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.line_done |-> out_item_reg.verdict == VERDICT_BLANK)
        else $error("verdict without line end");

    // untagged results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.text_kind == KIND_NONE |-> out_item_reg.text_byte == '0)
        else $error("byte present without text kind");

    // a held result stays put while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("result changed while stalled");

endmodule

// ----- hdl/ilc_char_class.sv -----
// ----------------------------------------------------------------------------
// ilc_char_class
// decodes one line byte into the character classes used by the parser
// ----------------------------------------------------------------------------
module ilc_char_class
    import ilc_pkg::*;
(
    input  logic [7:0]  line_byte,
    output char_class_t cls
);

    logic alpha;
    logic digit;
    logic special;

    always_comb
    begin
        alpha   = (line_byte inside {[8'h61:8'h7a], [8'h41:8'h5a]});
        digit   = (line_byte inside {[8'h30:8'h39]});
        special = (line_byte inside {CH_USCORE, 8'h2d, 8'h2b, 8'h2e, 8'h2c, 8'h3a,
                                     8'h27, 8'h28, 8'h29, CH_LBR, CH_RBR, 8'h7b,
                                     8'h7d, 8'h5c, 8'h2f});

        cls.zero       = (line_byte == CH_NUL);
        cls.space      = (line_byte == CH_SPACE) || (line_byte inside {[8'h09:8'h0d]});
        cls.comment    = (line_byte == CH_SEMI) || (line_byte == CH_HASH);
        cls.name_start = alpha || (line_byte == CH_USCORE);
        cls.name_char  = alpha || digit || (line_byte == CH_USCORE);
        cls.value_char = alpha || digit || special;
        cls.lbr        = (line_byte == CH_LBR);
        cls.rbr        = (line_byte == CH_RBR);
        cls.eq         = (line_byte == CH_EQ);
        cls.quote      = (line_byte == CH_QUOTE);
        // plain space only, allowed inside quotes
        cls.blank      = (line_byte == CH_SPACE);
    end

endmodule

// ----- hdl/ilc_line_fsm.sv -----
// ----------------------------------------------------------------------------
// ilc_line_fsm
// parse state of the current line: phase and text length, one byte per step
// ----------------------------------------------------------------------------
module ilc_line_fsm
    import ilc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  in_item_t    item,
    input  char_class_t cls,
    output out_item_t   result
);

    localparam logic [3:0] PH_LEAD       = 4'd0;
    localparam logic [3:0] PH_BLANK_REST = 4'd1;
    localparam logic [3:0] PH_SEC_PRE    = 4'd2;
    localparam logic [3:0] PH_SEC_NAME   = 4'd3;
    localparam logic [3:0] PH_SEC_POST   = 4'd4;
    localparam logic [3:0] PH_SEC_TAIL   = 4'd5;
    localparam logic [3:0] PH_SEC_REST   = 4'd6;
    localparam logic [3:0] PH_KEY        = 4'd7;
    localparam logic [3:0] PH_KEY_POST   = 4'd8;
    localparam logic [3:0] PH_VAL_PRE    = 4'd9;
    localparam logic [3:0] PH_VAL_BARE   = 4'd10;
    localparam logic [3:0] PH_VAL_QUOTED = 4'd11;
    localparam logic [3:0] PH_VAL_TAIL   = 4'd12;
    localparam logic [3:0] PH_PAIR_REST  = 4'd13;
    localparam logic [3:0] PH_INVALID    = 4'd14;

    localparam logic [TLEN_W-1:0] LEN_LIMIT = TLEN_W'(MAX_TEXT - 1);

    logic [3:0]        phase_reg;
    logic [3:0]        phase_next;
    logic [TLEN_W-1:0] len_reg;
    logic [TLEN_W-1:0] len_next;

    logic [3:0]        ph_a;
    logic [3:0]        ph_b;
    logic [TLEN_W-1:0] len_a;
    logic [1:0]        cap_kind;
    logic              cap_req;
    logic              cap_fresh;
    logic [TLEN_W-1:0] cap_base;

    // frozen phase that holds the verdict once content has ended
    function automatic logic [3:0] end_content(input logic [3:0] ph);
        logic [3:0] r;
        case (ph)
            PH_LEAD, PH_BLANK_REST:                          r = PH_BLANK_REST;
            PH_SEC_TAIL, PH_SEC_REST:                        r = PH_SEC_REST;
            PH_VAL_PRE, PH_VAL_BARE, PH_VAL_TAIL, PH_PAIR_REST: r = PH_PAIR_REST;
            default:                                         r = PH_INVALID;
        endcase
        return r;
    endfunction

    always_comb
    begin
        ph_a      = phase_reg;
        len_a     = len_reg;
        cap_req   = 1'b0;
        cap_fresh = 1'b0;
        cap_kind  = KIND_NONE;

        if (cls.zero)
        begin
            ph_a = end_content(phase_reg);
        end
        else
        begin
            case (phase_reg)
                PH_LEAD:
                    if (!cls.space)
                    begin
                        if (cls.comment)
                            ph_a = PH_BLANK_REST;
                        else if (cls.lbr)
                            ph_a = PH_SEC_PRE;
                        else if (cls.name_start)
                        begin
                            ph_a = PH_KEY; cap_req = 1'b1; cap_fresh = 1'b1;
                            cap_kind = KIND_KEY;
                        end
                        else
                            ph_a = PH_INVALID;
                    end
                PH_SEC_PRE:
                    if (!cls.space)
                    begin
                        if (cls.name_start)
                        begin
                            ph_a = PH_SEC_NAME; cap_req = 1'b1; cap_fresh = 1'b1;
                            cap_kind = KIND_SECTION;
                        end
                        else
                            ph_a = PH_INVALID;
                    end
                PH_SEC_NAME:
                    if (cls.name_char)
                    begin
                        cap_req = 1'b1; cap_kind = KIND_SECTION;
                    end
                    else if (cls.space)
                        ph_a = PH_SEC_POST;
                    else if (cls.rbr)
                        ph_a = PH_SEC_TAIL;
                    else
                        ph_a = PH_INVALID;
                PH_SEC_POST:
                    if (!cls.space)
                        ph_a = cls.rbr ? PH_SEC_TAIL : PH_INVALID;
                PH_SEC_TAIL:
                    if (!cls.space)
                        ph_a = cls.comment ? PH_SEC_REST : PH_INVALID;
                PH_KEY:
                    if (cls.name_char)
                    begin
                        cap_req = 1'b1; cap_kind = KIND_KEY;
                    end
                    else if (cls.space)
                        ph_a = PH_KEY_POST;
                    else if (cls.eq)
                    begin
                        ph_a = PH_VAL_PRE; len_a = '0;
                    end
                    else
                        ph_a = PH_INVALID;
                PH_KEY_POST:
                    if (!cls.space)
                    begin
                        if (cls.eq)
                        begin
                            ph_a = PH_VAL_PRE; len_a = '0;
                        end
                        else
                            ph_a = PH_INVALID;
                    end
                PH_VAL_PRE:
                    if (!cls.space)
                    begin
                        if (cls.comment)
                            ph_a = PH_PAIR_REST;
                        else if (cls.quote)
                        begin
                            ph_a = PH_VAL_QUOTED; len_a = '0;
                        end
                        else if (cls.value_char)
                        begin
                            ph_a = PH_VAL_BARE; cap_req = 1'b1; cap_fresh = 1'b1;
                            cap_kind = KIND_VALUE;
                        end
                        else
                            ph_a = PH_INVALID;
                    end
                PH_VAL_BARE:
                    if (cls.value_char)
                    begin
                        cap_req = 1'b1; cap_kind = KIND_VALUE;
                    end
                    else if (cls.space)
                        ph_a = PH_VAL_TAIL;
                    else if (cls.comment)
                        ph_a = PH_PAIR_REST;
                    else
                        ph_a = PH_INVALID;
                PH_VAL_QUOTED:
                    if (cls.value_char || cls.blank)
                    begin
                        cap_req = 1'b1; cap_kind = KIND_VALUE;
                    end
                    else if (cls.quote)
                        ph_a = PH_VAL_TAIL;
                    else
                        ph_a = PH_INVALID;
                PH_VAL_TAIL:
                    if (!cls.space)
                        ph_a = cls.comment ? PH_PAIR_REST : PH_INVALID;
                PH_BLANK_REST, PH_SEC_REST, PH_PAIR_REST, PH_INVALID:
                    ph_a = phase_reg;
                default:
                    ph_a = PH_INVALID;
            endcase
        end

        // capture with overflow check; a fresh text starts from zero length
        cap_base = cap_fresh ? '0 : len_reg;
        result.text_kind = KIND_NONE;
        result.text_byte = '0;
        if (cap_req)
        begin
            if (cap_base >= LEN_LIMIT)
            begin
                ph_a  = PH_INVALID;
                len_a = cap_base;
            end
            else
            begin
                len_a = cap_base + 1'b1;
                result.text_kind = cap_kind;
                result.text_byte = item.line_byte;
            end
        end

        ph_b = end_content(ph_a);
        result.line_done = item.line_end;
        result.verdict   = VERDICT_BLANK;
        if (item.line_end)
        begin
            case (ph_b)
                PH_BLANK_REST: result.verdict = VERDICT_BLANK;
                PH_SEC_REST:   result.verdict = VERDICT_SECTION;
                PH_PAIR_REST:  result.verdict = VERDICT_PAIR;
                default:       result.verdict = VERDICT_INVALID;
            endcase
            phase_next = PH_LEAD;
            len_next   = '0;
        end
        else
        begin
            phase_next = ph_a;
            len_next   = len_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            len_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
        end
    end

    // a finished line always leaves the parser at line start
    assert property (@(posedge clk) disable iff (!rst_n)
        step && item.line_end |=> phase_reg == PH_LEAD && len_reg == '0)
        else $error("parser not back at line start after line end");

    // text length never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_LIMIT)
        else $error("text length beyond limit");

    // a tagged character always counts toward the text length
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.text_kind != KIND_NONE && !item.line_end
        |=> len_reg != '0)
        else $error("tagged character not counted");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ini line classifier: a short stimulus table,
// then lines that force the text length limit, then random ini lines (mostly
// well formed, some corrupted, some pure noise). each result is compared with an
// in-bench parser model or a typed row's item, with random idle and stall bursts.
// ----------------------------------------------------------------------------
module testbench
    import ilc_pkg::*;
();

    localparam int RANDOM_ITEMS = 100;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [3:0] {
        P_LEAD, P_BLANK_REST, P_SEC_PRE, P_SEC_NAME, P_SEC_POST, P_SEC_TAIL,
        P_SEC_REST, P_KEY, P_KEY_POST, P_VAL_PRE, P_VAL_BARE, P_VAL_QUOTED,
        P_VAL_TAIL, P_PAIR_REST, P_INVALID
    } parse_phase_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         typed;
        out_item_t  want;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // parser model state
    parse_phase_t line_phase = P_LEAD;
    int           text_len = 0;
    out_item_t    step_out;

    out_item_t   pending_results[$];
    stim_row_t   stim_table[$];
    logic [7:0]  line_buf[$];
    int          mismatches = 0;
    int          sent_items = 0;
    int unsigned cycle_count = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_stall_en = 1'b1;

    string name_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string name_body = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string value_marks = "_-+.,:'()[]{}\\/";
    string value_body = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-+.,:'()[]{}\\/";

    ini_line_classifier_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    function automatic bit is_ws(logic [7:0] b);
        return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_comment_char(logic [7:0] b);
        return b == CH_SEMI || b == CH_HASH;
    endfunction

    function automatic bit is_name_start(logic [7:0] b);
        return is_alpha(b) || b == CH_USCORE;
    endfunction

    function automatic bit is_name_char(logic [7:0] b);
        return is_name_start(b) || is_digit(b);
    endfunction

    function automatic bit is_value_char(logic [7:0] b, bit quoted);
        bit hit;
        hit = is_alpha(b) || is_digit(b) || (quoted && b == CH_SPACE);
        for (int i = 0; i < value_marks.len(); i++)
            if (b == value_marks[i])
                hit = 1'b1;
        return hit;
    endfunction

    function automatic void take_char(logic [1:0] kind, logic [7:0] b);
        if (text_len >= MAX_TEXT - 1)
            line_phase = P_INVALID;
        else
        begin
            step_out.text_kind = kind;
            step_out.text_byte = b;
            text_len++;
        end
    endfunction

    function automatic void open_text(parse_phase_t nxt, logic [1:0] kind, logic [7:0] b);
        line_phase = nxt;
        text_len = 0;
        take_char(kind, b);
    endfunction

    // freeze the phase that decides the verdict
    function automatic void close_content();
        case (line_phase)
            P_LEAD, P_BLANK_REST: line_phase = P_BLANK_REST;
            P_SEC_TAIL, P_SEC_REST: line_phase = P_SEC_REST;
            P_VAL_PRE, P_VAL_BARE, P_VAL_TAIL, P_PAIR_REST: line_phase = P_PAIR_REST;
            default: line_phase = P_INVALID;
        endcase
    endfunction

    function automatic void advance(logic [7:0] b);
        case (line_phase)
            P_LEAD:
                if (!is_ws(b))
                begin
                    if (is_comment_char(b))
                        line_phase = P_BLANK_REST;
                    else if (b == CH_LBR)
                        line_phase = P_SEC_PRE;
                    else if (is_name_start(b))
                        open_text(P_KEY, KIND_KEY, b);
                    else
                        line_phase = P_INVALID;
                end
            P_SEC_PRE:
                if (!is_ws(b))
                begin
                    if (is_name_start(b))
                        open_text(P_SEC_NAME, KIND_SECTION, b);
                    else
                        line_phase = P_INVALID;
                end
            P_SEC_NAME:
                if (is_name_char(b))
                    take_char(KIND_SECTION, b);
                else if (is_ws(b))
                    line_phase = P_SEC_POST;
                else if (b == CH_RBR)
                    line_phase = P_SEC_TAIL;
                else
                    line_phase = P_INVALID;
            P_SEC_POST:
                if (!is_ws(b))
                    line_phase = (b == CH_RBR) ? P_SEC_TAIL : P_INVALID;
            P_SEC_TAIL:
                if (!is_ws(b))
                    line_phase = is_comment_char(b) ? P_SEC_REST : P_INVALID;
            P_KEY:
                if (is_name_char(b))
                    take_char(KIND_KEY, b);
                else if (is_ws(b))
                    line_phase = P_KEY_POST;
                else if (b == CH_EQ)
                begin
                    line_phase = P_VAL_PRE;
                    text_len = 0;
                end
                else
                    line_phase = P_INVALID;
            P_KEY_POST:
                if (!is_ws(b))
                begin
                    if (b == CH_EQ)
                    begin
                        line_phase = P_VAL_PRE;
                        text_len = 0;
                    end
                    else
                        line_phase = P_INVALID;
                end
            P_VAL_PRE:
                if (!is_ws(b))
                begin
                    if (is_comment_char(b))
                        line_phase = P_PAIR_REST;
                    else if (b == CH_QUOTE)
                    begin
                        line_phase = P_VAL_QUOTED;
                        text_len = 0;
                    end
                    else if (is_value_char(b, 1'b0))
                        open_text(P_VAL_BARE, KIND_VALUE, b);
                    else
                        line_phase = P_INVALID;
                end
            P_VAL_BARE:
                if (is_value_char(b, 1'b0))
                    take_char(KIND_VALUE, b);
                else if (is_ws(b))
                    line_phase = P_VAL_TAIL;
                else if (is_comment_char(b))
                    line_phase = P_PAIR_REST;
                else
                    line_phase = P_INVALID;
            P_VAL_QUOTED:
                if (is_value_char(b, 1'b1))
                    take_char(KIND_VALUE, b);
                else if (b == CH_QUOTE)
                    line_phase = P_VAL_TAIL;
                else
                    line_phase = P_INVALID;
            P_VAL_TAIL:
                if (!is_ws(b))
                    line_phase = is_comment_char(b) ? P_PAIR_REST : P_INVALID;
            P_BLANK_REST, P_SEC_REST, P_PAIR_REST, P_INVALID: ;
            default: line_phase = P_INVALID;
        endcase
    endfunction

    function automatic out_item_t classify_byte(in_item_t it);
        step_out = '0;
        if (it.line_byte == CH_NUL)
            close_content();
        else
            advance(it.line_byte);
        if (it.line_end)
        begin
            close_content();
            step_out.line_done = 1'b1;
            case (line_phase)
                P_BLANK_REST: step_out.verdict = VERDICT_BLANK;
                P_SEC_REST: step_out.verdict = VERDICT_SECTION;
                P_PAIR_REST: step_out.verdict = VERDICT_PAIR;
                default: step_out.verdict = VERDICT_INVALID;
            endcase
            line_phase = P_LEAD;
            text_len = 0;
        end
        return step_out;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic out_item_t line_verdict(logic [1:0] v);
        out_item_t r;
        r = '0;
        r.line_done = 1'b1;
        r.verdict = v;
        return r;
    endfunction

    function automatic void add_row(logic [7:0] ch, logic last, bit typed, out_item_t want);
        stim_row_t r;
        r.ch = ch;
        r.last = last;
        r.typed = typed;
        r.want = want;
        stim_table.push_back(r);
    endfunction

    function automatic void put_ws(int max_n);
        int n;
        repeat ($urandom_range(0, max_n))
        begin
            n = $urandom_range(0, 5);
            line_buf.push_back(n == 0 ? CH_SPACE : 8'(8 + n));
        end
    endfunction

    function automatic void put_name(int len);
        for (int i = 0; i < len; i++)
            if (i == 0)
                line_buf.push_back(name_head[$urandom_range(0, name_head.len() - 1)]);
            else
                line_buf.push_back(name_body[$urandom_range(0, name_body.len() - 1)]);
    endfunction

    function automatic void put_value(int len, bit quoted);
        for (int i = 0; i < len; i++)
            if (quoted && $urandom_range(0, 7) == 0)
                line_buf.push_back(CH_SPACE);
            else
                line_buf.push_back(value_body[$urandom_range(0, value_body.len() - 1)]);
    endfunction

    // trailing whitespace and an optional comment with arbitrary content
    function automatic void put_tail();
        put_ws(2);
        if ($urandom_range(0, 2) == 0)
        begin
            line_buf.push_back($urandom_range(0, 1) ? CH_SEMI : CH_HASH);
            repeat ($urandom_range(0, 4))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 24) == 0)
            return $urandom_range(MAX_TEXT - 2, MAX_TEXT + 1);
        return $urandom_range(1, 6);
    endfunction

    // 0 blank or comment, 1 section, 2 bare pair, 3 quoted pair, else noise
    function automatic void make_line(int kind, int key_len, int txt_len);
        line_buf.delete();
        case (kind)
            0:
            begin
                put_ws(3);
                if ($urandom_range(0, 1))
                    put_tail();
            end
            1:
            begin
                put_ws(2);
                line_buf.push_back(CH_LBR);
                put_ws(1);
                put_name(txt_len);
                put_ws(1);
                line_buf.push_back(CH_RBR);
                put_tail();
            end
            2, 3:
            begin
                put_ws(2);
                put_name(key_len);
                put_ws(1);
                line_buf.push_back(CH_EQ);
                put_ws(1);
                if (kind == 3)
                begin
                    line_buf.push_back(CH_QUOTE);
                    put_value(txt_len, 1'b1);
                    line_buf.push_back(CH_QUOTE);
                end
                else if ($urandom_range(0, 5) != 0)
                    put_value(txt_len, 1'b0);
                put_tail();
            end
            default:
                repeat ($urandom_range(1, 8))
                    line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
        if (line_buf.size() == 0)
            line_buf.push_back(CH_SPACE);
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t predicted;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = classify_byte(it);
        pending_results.push_back(typed ? want : predicted);
        sent_items++;
    endtask

    task automatic send_line();
        in_item_t it;
        for (int i = 0; i < line_buf.size(); i++)
        begin
            it.line_byte = line_buf[i];
            it.line_end = (i == line_buf.size() - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    // hold off until every outstanding transaction has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.text_kind !== want.text_kind)
            begin
                $display("%0t: text_kind expected %0d actual %0d", $time,
                         want.text_kind, got.text_kind);
                mismatches++;
            end
            if (got.text_byte !== want.text_byte)
            begin
                $display("%0t: text_byte expected %h actual %h", $time,
                         want.text_byte, got.text_byte);
                mismatches++;
            end
            if (got.line_done !== want.line_done)
            begin
                $display("%0t: line_done expected %0d actual %0d", $time,
                         want.line_done, got.line_done);
                mismatches++;
            end
            if (got.verdict !== want.verdict)
            begin
                $display("%0t: verdict expected %0d actual %0d", $time,
                         want.verdict, got.verdict);
                mismatches++;
            end
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_result(out_item);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (rx_stall_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int random_start;
        int line_no;
        int r;
        in_item_t it;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero byte alone, top byte alone, bare comment
        add_row(CH_NUL, 1'b1, 1'b1, line_verdict(VERDICT_BLANK));
        add_row(8'hff, 1'b1, 1'b1, line_verdict(VERDICT_INVALID));
        add_row(CH_HASH, 1'b1, 1'b1, line_verdict(VERDICT_BLANK));
        // [x]
        add_row(CH_LBR, 1'b0, 1'b0, '0);
        add_row("x", 1'b0, 1'b0, '0);
        add_row(CH_RBR, 1'b1, 1'b0, '0);
        // empty value
        add_row("k", 1'b0, 1'b0, '0);
        add_row(CH_EQ, 1'b1, 1'b0, '0);
        // quoted value holding a space
        add_row("k", 1'b0, 1'b0, '0);
        add_row(CH_EQ, 1'b0, 1'b0, '0);
        add_row(CH_QUOTE, 1'b0, 1'b0, '0);
        add_row(CH_SPACE, 1'b0, 1'b0, '0);
        add_row(CH_QUOTE, 1'b1, 1'b0, '0);
        // zero byte mid line, later byte ignored
        add_row("v", 1'b0, 1'b0, '0);
        add_row(CH_EQ, 1'b0, 1'b0, '0);
        add_row("a", 1'b0, 1'b0, '0);
        add_row(CH_NUL, 1'b0, 1'b0, '0);
        add_row("!", 1'b1, 1'b0, '0);
        // digit cannot start a key
        add_row(CH_SPACE, 1'b0, 1'b1, '0);
        add_row("9", 1'b1, 1'b0, '0);
        // unfinished section header
        add_row(CH_LBR, 1'b1, 1'b1, line_verdict(VERDICT_INVALID));

        foreach (stim_table[i])
        begin
            it.line_byte = stim_table[i].ch;
            it.line_end = stim_table[i].last;
            send_item(it, stim_table[i].typed, stim_table[i].want);
        end
        drain();

        // text length at and just past the limit
        make_line(1, 0, MAX_TEXT - 1);
        send_line();
        make_line(2, MAX_TEXT, 3);
        send_line();
        make_line(3, 2, MAX_TEXT);
        send_line();
        make_line(2, 1, MAX_TEXT - 1);
        send_line();

        random_start = sent_items;
        line_no = 0;
        while (sent_items < random_start + RANDOM_ITEMS)
        begin
            if (sent_items >= random_start + RANDOM_ITEMS - 60)
            begin
                tx_idle_en = 1'b0;
                rx_stall_en = 1'b0;
            end
            else
            begin
                tx_idle_en = ($urandom_range(0, 2) != 0);
                rx_stall_en = ($urandom_range(0, 2) != 0);
            end
            if (line_no == 3)
                drain();
            r = $urandom_range(0, 19);
            make_line(r < 3 ? 0 : r < 7 ? 1 : r < 12 ? 2 : r < 16 ? 3 : 4,
                      pick_len(), pick_len());
            // occasional corruption of an otherwise sane line
            if ($urandom_range(0, 7) == 0)
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
            send_line();
            line_no++;
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
